### rtl/frns_pkg.sv
// Shared types, constants and helpers for the fixed-radius neighbor search block.
package frns_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int COORD_W    = 16;
  localparam int ELEM_W     = 7;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 3;
  localparam int RADIUS_W   = 16;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int LIM_W      = 2 * RADIUS_W;

  localparam logic [RADIUS_W-1:0] CUTOFF_RESET = 16'd2560;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_STORED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NEIGHBOR = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NONE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_WAIT = 3'b100
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } pos_t;

  typedef struct packed {
    logic [ELEM_W-1:0] elem;
    pos_t              pos;
  } point_t;

  localparam int POINT_W = $bits(point_t);

  typedef struct packed {
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] idx;
  } scan_tag_t;

  typedef struct packed {
    logic             valid;
    logic             match;
    logic             last;
    logic [IDX_W-1:0] idx;
    point_t           pt;
  } dist_res_t;

  function automatic logic [COORD_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                  input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    logic signed [COORD_W:0] n;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    n = -d;
    return d[COORD_W] ? n[COORD_W-1:0] : d[COORD_W-1:0];
  endfunction

endpackage

### rtl/fixed_radius_neighbor_search_top.sv
// Top level of the fixed-radius neighbor search block: control, table and output.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------------
//  input    | start / busy       | in_cmd, in_pos_x/y/z, in_element_code
//  result   | out_valid strobe   | out_status, out_entry_index, out_found_*, out_last
//  config   | cfg_we             | cfg_wdata (cutoff radius)
//
//  Insert and clear answer in the next cycle; unused commands do nothing; busy stays low.
//  A query over N stored points makes one table read per cycle through the
//  point RAM port, then passes the distance pipeline and output stage.
//  An empty-table query answers in the next cycle.
//  Synchronous reset empties the table and restores the cutoff radius.
//  Results are strobed for one cycle; the receiver cannot stall them.
module fixed_radius_neighbor_search_top import frns_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [CMD_W-1:0]           in_cmd,
  input  logic signed [COORD_W-1:0]  in_pos_x,
  input  logic signed [COORD_W-1:0]  in_pos_y,
  input  logic signed [COORD_W-1:0]  in_pos_z,
  input  logic [ELEM_W-1:0]          in_element_code,
  output logic                       out_valid,
  output logic [STATUS_W-1:0]        out_status,
  output logic [IDX_W-1:0]           out_entry_index,
  output logic [ELEM_W-1:0]          out_found_element,
  output logic signed [COORD_W-1:0]  out_found_x,
  output logic signed [COORD_W-1:0]  out_found_y,
  output logic signed [COORD_W-1:0]  out_found_z,
  output logic                       out_last,
  input  logic                       cfg_we,
  input  logic [RADIUS_W-1:0]        cfg_wdata
);

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [IDX_W-1:0]     scan_idx_r, scan_idx_nxt;
  logic [RADIUS_W-1:0]  cutoff_r, cutoff_nxt;
  logic [LIM_W-1:0]     lim_r;
  pos_t                 q_r, q_nxt;
  logic                 fin_r, fin_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic [IDX_W-1:0]     pend_idx_r, pend_idx_nxt;
  point_t               pend_pt_r, pend_pt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [IDX_W-1:0]     out_idx_r, out_idx_nxt;
  point_t               out_pt_r, out_pt_nxt;
  logic                 out_last_r, out_last_nxt;
  scan_tag_t            tag_r, tag_nxt;
  logic                 ram_we, ram_re;
  point_t               wr_pt;
  logic [POINT_W-1:0]   rd_data;
  point_t               rd_pt;
  dist_res_t            res;
  logic                 scan_last;

  assign busy  = (state_r != S_IDLE);
  assign wr_pt = '{elem: in_element_code, pos: '{x: in_pos_x, y: in_pos_y, z: in_pos_z}};
  assign rd_pt = point_t'(rd_data);
  assign scan_last = (CNT_W'(scan_idx_r) == count_r - CNT_W'(1));

  frns_ram #(
    .WIDTH (POINT_W),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (wr_pt),
    .re    (ram_re),
    .raddr (scan_idx_r),
    .rdata (rd_data)
  );

  frns_dist u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .tag   (tag_r),
    .pt    (rd_pt),
    .q     (q_r),
    .lim   (lim_r),
    .res   (res)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_idx_nxt   = scan_idx_r;
    cutoff_nxt     = cfg_we ? cfg_wdata : cutoff_r;
    q_nxt          = q_r;
    fin_nxt        = 1'b0;
    pend_v_nxt     = pend_v_r;
    pend_idx_nxt   = pend_idx_r;
    pend_pt_nxt    = pend_pt_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = ST_STORED;
    out_idx_nxt    = '0;
    out_pt_nxt     = '0;
    out_last_nxt   = 1'b1;
    tag_nxt        = '0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_cmd)
            CMD_INSERT: begin
              out_valid_nxt = 1'b1;
              if (count_r == CNT_W'(MAX_POINTS)) begin
                out_status_nxt = ST_FULL;
              end else begin
                ram_we         = 1'b1;
                out_status_nxt = ST_STORED;
                out_idx_nxt    = count_r[IDX_W-1:0];
                count_nxt      = count_r + CNT_W'(1);
              end
            end
            CMD_QUERY: begin
              q_nxt = wr_pt.pos;
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_NONE;
              end else begin
                state_nxt    = S_SCAN;
                scan_idx_nxt = '0;
                pend_v_nxt   = 1'b0;
              end
            end
            CMD_CLEAR: begin
              count_nxt      = '0;
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_CLEARED;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        ram_re  = 1'b1;
        tag_nxt = '{valid: 1'b1, last: scan_last, idx: scan_idx_r};
        if (scan_last) begin
          state_nxt = S_WAIT;
        end else begin
          scan_idx_nxt = scan_idx_r + IDX_W'(1);
        end
      end
      S_WAIT: begin
        if (fin_r) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          pend_v_nxt    = 1'b0;
          if (pend_v_r) begin
            out_status_nxt = ST_NEIGHBOR;
            out_idx_nxt    = pend_idx_r;
            out_pt_nxt     = pend_pt_r;
          end else begin
            out_status_nxt = ST_NONE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // hold one match back so the final one can carry last
    if (res.valid && res.match) begin
      if (pend_v_r) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_NEIGHBOR;
        out_idx_nxt    = pend_idx_r;
        out_pt_nxt     = pend_pt_r;
        out_last_nxt   = 1'b0;
      end
      pend_v_nxt   = 1'b1;
      pend_idx_nxt = res.idx;
      pend_pt_nxt  = res.pt;
    end
    if (res.valid && res.last) begin
      fin_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cutoff_r    <= CUTOFF_RESET;
      fin_r       <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      tag_r.valid <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cutoff_r    <= cutoff_nxt;
      fin_r       <= fin_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      tag_r.valid <= tag_nxt.valid;
    end
    tag_r.last <= tag_nxt.last;
    tag_r.idx  <= tag_nxt.idx;
  end

  always_ff @(posedge clk) begin
    scan_idx_r   <= scan_idx_nxt;
    q_r          <= q_nxt;
    lim_r        <= LIM_W'(cutoff_r) * LIM_W'(cutoff_r);
    pend_idx_r   <= pend_idx_nxt;
    pend_pt_r    <= pend_pt_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_pt_r     <= out_pt_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_entry_index   = out_idx_r;
  assign out_found_element = out_pt_r.elem;
  assign out_found_x       = out_pt_r.pos.x;
  assign out_found_y       = out_pt_r.pos.y;
  assign out_found_z       = out_pt_r.pos.z;
  assign out_last          = out_last_r;

endmodule

### rtl/frns_ram.sv
// Single-port-write, registered-read RAM holding the point table.
module frns_ram #(
  parameter int WIDTH = 55,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/frns_dist.sv
// Three-stage squared-distance and cutoff compare pipeline; zero distance never matches.
module frns_dist import frns_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  scan_tag_t        tag,
  input  point_t           pt,
  input  pos_t             q,
  input  logic [LIM_W-1:0] lim,
  output dist_res_t        res
);

  scan_tag_t          s1_tag_r, s2_tag_r;
  point_t             s1_pt_r, s2_pt_r;
  logic [COORD_W-1:0] ax_r, ay_r, az_r;
  logic [SQ_W-1:0]    sx_r, sy_r, sz_r;
  logic [SUM_W-1:0]   d2;
  logic               match;

  assign d2    = SUM_W'(sx_r) + SUM_W'(sy_r) + SUM_W'(sz_r);
  assign match = (d2 <= SUM_W'(lim)) && (d2 != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r.valid <= 1'b0;
      s2_tag_r.valid <= 1'b0;
      res.valid      <= 1'b0;
    end else begin
      s1_tag_r.valid <= tag.valid;
      s2_tag_r.valid <= s1_tag_r.valid;
      res.valid      <= s2_tag_r.valid;
    end
    s1_tag_r.last <= tag.last;
    s1_tag_r.idx  <= tag.idx;
    s1_pt_r       <= pt;
    ax_r          <= abs_diff(q.x, pt.pos.x);
    ay_r          <= abs_diff(q.y, pt.pos.y);
    az_r          <= abs_diff(q.z, pt.pos.z);
    s2_tag_r.last <= s1_tag_r.last;
    s2_tag_r.idx  <= s1_tag_r.idx;
    s2_pt_r       <= s1_pt_r;
    sx_r          <= SQ_W'(ax_r) * SQ_W'(ax_r);
    sy_r          <= SQ_W'(ay_r) * SQ_W'(ay_r);
    sz_r          <= SQ_W'(az_r) * SQ_W'(az_r);
    res.match     <= match;
    res.last      <= s2_tag_r.last;
    res.idx       <= s2_tag_r.idx;
    res.pt        <= s2_pt_r;
  end

endmodule

### rtl/frns_checker.sv
// Port-level assertions for the fixed-radius neighbor search block, bound to the top.
module frns_checker import frns_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic [CMD_W-1:0]          in_cmd,
  input logic                      out_valid,
  input logic [STATUS_W-1:0]       out_status,
  input logic                      out_last
);

  // insert answers in the next cycle with stored or full
  a_insert_resp: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_cmd == CMD_INSERT |=>
      out_valid && out_last && (out_status == ST_STORED || out_status == ST_FULL))
    else $error("insert transaction without stored/full result");

  // clear answers in the next cycle
  a_clear_resp: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_cmd == CMD_CLEAR |=>
      out_valid && out_last && out_status == ST_CLEARED)
    else $error("clear transaction without cleared result");

  // only neighbor results may be non-final
  a_nonlast_neighbor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == ST_NEIGHBOR)
    else $error("non-final result that is not a neighbor");

  // the final result of a transaction coincides with the block going idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy)
    else $error("final result while still busy");

  // non-final results only occur while a query scan is running
  a_nonlast_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("non-final result outside a query");

endmodule

bind fixed_radius_neighbor_search_top frns_checker u_frns_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_cmd     (in_cmd),
  .out_valid  (out_valid),
  .out_status (out_status),
  .out_last   (out_last)
);
